[rtl/boris_particle_push_defines.svh]
// assertion macros for the boris particle push block
// used by the top level only; no other dependencies
`ifndef BORIS_PARTICLE_PUSH_DEFINES_SVH
`define BORIS_PARTICLE_PUSH_DEFINES_SVH

// same-cycle implication under reset
`define BPP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("boris push: implication check failed");

// next-cycle implication under reset
`define BPP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("boris push: next-cycle check failed");

`endif

[rtl/bpp_pkg.sv]
// shared types and constants for the boris particle push block
// no dependencies
package bpp_pkg;

  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_WORD_WIDTH = 32;
  localparam int IO_W           = 32;
  localparam int CFG_W          = 32;
  localparam int DT_W           = 31;

  typedef enum logic [0:0] {
    CFG_STEP_FACTOR = 1'b0,
    CFG_TIME_STEP   = 1'b1
  } bpp_cfg_idx_t;

  typedef struct packed {
    logic signed [IO_W-1:0] vel_x;
    logic signed [IO_W-1:0] vel_y;
    logic signed [IO_W-1:0] vel_z;
    logic signed [IO_W-1:0] pos_x;
    logic signed [IO_W-1:0] pos_y;
    logic signed [IO_W-1:0] pos_z;
    logic signed [IO_W-1:0] efield_x;
    logic signed [IO_W-1:0] efield_y;
    logic signed [IO_W-1:0] efield_z;
    logic signed [IO_W-1:0] bfield_x;
    logic signed [IO_W-1:0] bfield_y;
    logic signed [IO_W-1:0] bfield_z;
  } bpp_in_t;

  typedef struct packed {
    logic signed [IO_W-1:0] new_vel_x;
    logic signed [IO_W-1:0] new_vel_y;
    logic signed [IO_W-1:0] new_vel_z;
    logic signed [IO_W-1:0] new_pos_x;
    logic signed [IO_W-1:0] new_pos_y;
    logic signed [IO_W-1:0] new_pos_z;
  } bpp_out_t;

endpackage

[rtl/bpp_div.sv]
// pipelined restoring divider, one quotient bit per stage
// computes (mag << (frac+1)) / den; depends on nothing but its parameters
module bpp_div #(
  parameter int W      = 32,
  parameter int F      = 16,
  parameter int SIDE_W = 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [W-1:0]                           in_mag,
  input  logic [((F+1 > W) ? F+1 : W):0]         in_den,
  input  logic [SIDE_W-1:0]                      in_side,
  output logic                                   out_valid,
  output logic [W+F:0]                           out_quo,
  output logic [SIDE_W-1:0]                      out_side
);

  localparam int NW = W + F + 1;
  localparam int DW = ((F + 1 > W) ? F + 1 : W) + 1;

  logic              valid_r [NW];
  logic [NW-1:0]     num_r   [NW];
  logic [DW-1:0]     rem_r   [NW];
  logic [NW-1:0]     quo_r   [NW];
  logic [DW-1:0]     den_r   [NW];
  logic [SIDE_W-1:0] side_r  [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic              v_in;
    logic [NW-1:0]     num_in;
    logic [DW-1:0]     rem_in;
    logic [NW-1:0]     quo_in;
    logic [DW-1:0]     den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW:0]       trial;
    logic              ge;
    logic [DW-1:0]     rem_nxt;

    if (g == 0) begin : g_head
      assign v_in    = in_valid;
      assign num_in  = {in_mag, {(F+1){1'b0}}};
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_body
      assign v_in    = valid_r[g-1];
      assign num_in  = num_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign den_in  = den_r[g-1];
      assign side_in = side_r[g-1];
    end

    always_comb begin
      trial   = {rem_in, num_in[NW-1]};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= v_in;
      end
      if (en) begin
        num_r[g]  <= {num_in[NW-2:0], 1'b0};
        rem_r[g]  <= rem_nxt;
        quo_r[g]  <= {quo_in[NW-2:0], ge};
        den_r[g]  <= den_in;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[NW-1];
  assign out_quo   = quo_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

[rtl/boris_particle_push.sv]
// boris particle push top level: config registers, arithmetic pipeline
// depends on bpp_pkg, bpp_div and boris_particle_push_defines.svh
//
// Boris velocity push and position advance for a stream of particles. One
// item (velocity, position, E and B, three components each) is accepted
// every cycle while in_stall is low, and one result item (new velocity and
// position) leaves for each, in order. Values are Q16.16 at the default;
// most of the pipe is the three bit-serial dividers for s = 2h/(1+h.h), one
// quotient bit per stage. The whole pipe advances together: when a result
// waits under out_stall every stage holds and in_stall rises in the same
// cycle, so nothing is lost or repeated.
// Program step_factor (k = dt*q/2m) and time_step only while idle.
module boris_particle_push #(
  parameter int FRAC_BITS  = bpp_pkg::DEF_FRAC_BITS,
  parameter int WORD_WIDTH = bpp_pkg::DEF_WORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bpp_pkg::bpp_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bpp_pkg::bpp_out_t                out_data,
  input  logic                             cfg_we,
  input  bpp_pkg::bpp_cfg_idx_t            cfg_index,
  input  logic [bpp_pkg::CFG_W-1:0]        cfg_wdata
);
  import bpp_pkg::*;
  `include "boris_particle_push_defines.svh"

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 2;
  localparam int NW = W + F + 1;
  localparam int DW = ((F + 1 > W) ? F + 1 : W) + 1;
  localparam int OW = ((W > IO_W) ? W : IO_W) + 1;
  localparam int SW = 13 * W + 1;

  localparam logic signed [PW-1:0] WMAX_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] WMIN_P = ~WMAX_P;
  localparam logic signed [PW-1:0] HALF_P = {{(PW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [DW-1:0]        ONE_D  = {{(DW-1){1'b0}}, 1'b1} << F;
  localparam logic [NW:0]          QMAX   = {{(NW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [OW-1:0] OMAX   = {{(OW-IO_W+1){1'b0}}, {(IO_W-1){1'b1}}};
  localparam logic signed [OW-1:0] OMIN   = ~OMAX;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [W-1:0] sat_p(input logic signed [PW-1:0] v);
    if (v > WMAX_P) return WMAX_P[W-1:0];
    if (v < WMIN_P) return WMIN_P[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] from_io(input logic signed [IO_W-1:0] x);
    logic signed [PW-1:0] t;
    t = x;
    return sat_p(t);
  endfunction

  function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [PW-1:0] ae, be;
    ae = a;
    be = b;
    return sat_p(ae + be);
  endfunction

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [PW-1:0] ae, be;
    ae = a;
    be = b;
    return sat_p(ae - be);
  endfunction

  // product rounded to nearest, ties away from zero, then saturated
  function automatic logic signed [W-1:0] mul_s(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [PW-1:0] ae, be, pr, mg, rr;
    ae = a;
    be = b;
    pr = ae * be;
    mg = pr[PW-1] ? -pr : pr;
    rr = (mg + HALF_P) >>> F;
    if (pr[PW-1]) rr = -rr;
    return sat_p(rr);
  endfunction

  function automatic logic signed [IO_W-1:0] to_io(input logic signed [W-1:0] v);
    logic signed [OW-1:0] t;
    t = v;
    if (t > OMAX) return OMAX[IO_W-1:0];
    if (t < OMIN) return OMIN[IO_W-1:0];
    return t[IO_W-1:0];
  endfunction

  // ------------------------------------------------------- config registers
  logic signed [CFG_W-1:0] k_r;
  logic [DT_W-1:0]         dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      dt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_FACTOR: k_r  <= cfg_wdata;
        CFG_TIME_STEP:   dt_r <= cfg_wdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves together unless a finished item is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------------------------------- stage 1: clamp, e = E*k, h = B*k
  logic signed [W-1:0] vin [3], pin [3], ein [3], bin [3];
  logic signed [W-1:0] k_w, dt_w;
  logic                v1_r;
  logic signed [W-1:0] v1v_r [3], p1_r [3], e1_r [3], h1_r [3], dt1_r;

  always_comb begin
    vin[0] = from_io(in_data.vel_x);    vin[1] = from_io(in_data.vel_y);
    vin[2] = from_io(in_data.vel_z);
    pin[0] = from_io(in_data.pos_x);    pin[1] = from_io(in_data.pos_y);
    pin[2] = from_io(in_data.pos_z);
    ein[0] = from_io(in_data.efield_x); ein[1] = from_io(in_data.efield_y);
    ein[2] = from_io(in_data.efield_z);
    bin[0] = from_io(in_data.bfield_x); bin[1] = from_io(in_data.bfield_y);
    bin[2] = from_io(in_data.bfield_z);
    k_w    = from_io(k_r);
    dt_w   = from_io($signed({1'b0, dt_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1v_r[i] <= vin[i];
        p1_r[i]  <= pin[i];
        e1_r[i]  <= mul_s(ein[i], k_w);
        h1_r[i]  <= mul_s(bin[i], k_w);
      end
      dt1_r <= dt_w;
    end
  end

  // --------------------------------------------- stage 2: u = v + e, h*h
  logic                v2_r;
  logic signed [W-1:0] u2_r [3], sq2_r [3], h2_r [3], p2_r [3], e2_r [3], dt2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u2_r[i]  <= add_s(v1v_r[i], e1_r[i]);
        sq2_r[i] <= mul_s(h1_r[i], h1_r[i]);
        h2_r[i]  <= h1_r[i];
        p2_r[i]  <= p1_r[i];
        e2_r[i]  <= e1_r[i];
      end
      dt2_r <= dt1_r;
    end
  end

  // ---------------------------- stage 3: denominator, products of u x h
  logic signed [W-1:0] hh3;
  logic                v3_r;
  logic [DW-1:0]       den3_r;
  logic signed [W-1:0] pa3_r [3], pb3_r [3];
  logic signed [W-1:0] u3_r [3], h3_r [3], p3_r [3], e3_r [3], dt3_r;

  always_comb begin
    hh3 = add_s(add_s(sq2_r[0], sq2_r[1]), sq2_r[2]);
    if (hh3[W-1]) hh3 = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      den3_r <= ONE_D + DW'($unsigned(hh3));
      for (int i = 0; i < 3; i++) begin
        pa3_r[i] <= mul_s(u2_r[(i+1)%3], h2_r[(i+2)%3]);
        pb3_r[i] <= mul_s(u2_r[(i+2)%3], h2_r[(i+1)%3]);
        u3_r[i]  <= u2_r[i];
        h3_r[i]  <= h2_r[i];
        p3_r[i]  <= p2_r[i];
        e3_r[i]  <= e2_r[i];
      end
      dt3_r <= dt2_r;
    end
  end

  // ------------------------------------------------- stage 4: w = u + u x h
  logic                v4_r;
  logic [DW-1:0]       den4_r;
  logic signed [W-1:0] w4_r [3], u4_r [3], h4_r [3], p4_r [3], e4_r [3], dt4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      den4_r <= den3_r;
      for (int i = 0; i < 3; i++) begin
        w4_r[i] <= add_s(u3_r[i], sub_s(pa3_r[i], pb3_r[i]));
        u4_r[i] <= u3_r[i];
        h4_r[i] <= h3_r[i];
        p4_r[i] <= p3_r[i];
        e4_r[i] <= e3_r[i];
      end
      dt4_r <= dt3_r;
    end
  end

  // ------------------------------------ dividers: |2h| / den, one per axis
  logic [W-1:0]    hmag [3];
  logic [SW-1:0]   side0_in, side0_out;
  logic            sgn_out [3];
  logic            dv [3];
  logic [NW-1:0]   quo [3];
  logic            sgn12_out [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hmag[i] = h4_r[i][W-1] ? W'(-h4_r[i]) : W'(h4_r[i]);
    end
    side0_in = '0;
    for (int i = 0; i < 3; i++) begin
      side0_in[i*W +: W]     = u4_r[i];
      side0_in[(3+i)*W +: W] = w4_r[i];
      side0_in[(6+i)*W +: W] = e4_r[i];
      side0_in[(9+i)*W +: W] = p4_r[i];
    end
    side0_in[12*W +: W] = dt4_r;
    side0_in[SW-1]      = h4_r[0][W-1];
  end

  bpp_div #(.W(W), .F(F), .SIDE_W(SW)) u_div0 (
    .clk, .rst_n, .en,
    .in_valid (v4_r), .in_mag (hmag[0]), .in_den (den4_r), .in_side (side0_in),
    .out_valid(dv[0]), .out_quo (quo[0]), .out_side (side0_out)
  );

  bpp_div #(.W(W), .F(F), .SIDE_W(1)) u_div1 (
    .clk, .rst_n, .en,
    .in_valid (v4_r), .in_mag (hmag[1]), .in_den (den4_r), .in_side (h4_r[1][W-1]),
    .out_valid(dv[1]), .out_quo (quo[1]), .out_side (sgn12_out[0])
  );

  bpp_div #(.W(W), .F(F), .SIDE_W(1)) u_div2 (
    .clk, .rst_n, .en,
    .in_valid (v4_r), .in_mag (hmag[2]), .in_den (den4_r), .in_side (h4_r[2][W-1]),
    .out_valid(dv[2]), .out_quo (quo[2]), .out_side (sgn12_out[1])
  );

  assign sgn_out[0] = side0_out[SW-1];
  assign sgn_out[1] = sgn12_out[0];
  assign sgn_out[2] = sgn12_out[1];

  // ------------------------------------- stage 5: signed, saturated s
  logic signed [W-1:0] s5n [3];
  logic                v5_r;
  logic signed [W-1:0] s5_r [3], u5_r [3], w5_r [3], e5_r [3], p5_r [3], dt5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, quo[i]} > (QMAX + (NW+1)'(sgn_out[i]))) begin
        s5n[i] = sgn_out[i] ? WMIN_P[W-1:0] : WMAX_P[W-1:0];
      end else begin
        s5n[i] = sgn_out[i] ? W'(-quo[i][W-1:0]) : quo[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= dv[0];
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_r[i] <= s5n[i];
        u5_r[i] <= side0_out[i*W +: W];
        w5_r[i] <= side0_out[(3+i)*W +: W];
        e5_r[i] <= side0_out[(6+i)*W +: W];
        p5_r[i] <= side0_out[(9+i)*W +: W];
      end
      dt5_r <= side0_out[12*W +: W];
    end
  end

  // ------------------------------------------ stage 6: products of w x s
  logic                v6_r;
  logic signed [W-1:0] pa6_r [3], pb6_r [3], u6_r [3], e6_r [3], p6_r [3], dt6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa6_r[i] <= mul_s(w5_r[(i+1)%3], s5_r[(i+2)%3]);
        pb6_r[i] <= mul_s(w5_r[(i+2)%3], s5_r[(i+1)%3]);
        u6_r[i]  <= u5_r[i];
        e6_r[i]  <= e5_r[i];
        p6_r[i]  <= p5_r[i];
      end
      dt6_r <= dt5_r;
    end
  end

  // ------------------------------- stage 7: v' = u + w x s + e (second kick)
  logic                v7_r;
  logic signed [W-1:0] nv7_r [3], p7_r [3], dt7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nv7_r[i] <= add_s(add_s(u6_r[i], sub_s(pa6_r[i], pb6_r[i])), e6_r[i]);
        p7_r[i]  <= p6_r[i];
      end
      dt7_r <= dt6_r;
    end
  end

  // ------------------------------------------------ stage 8: v' * dt
  logic                v8_r;
  logic signed [W-1:0] nv8_r [3], pd8_r [3], p8_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nv8_r[i] <= nv7_r[i];
        pd8_r[i] <= mul_s(nv7_r[i], dt7_r);
        p8_r[i]  <= p7_r[i];
      end
    end
  end

  // ------------------------------ output register: p' = p + v'*dt, to io
  logic     out_valid_r;
  bpp_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v8_r;
    if (en) begin
      out_data_r.new_vel_x <= to_io(nv8_r[0]);
      out_data_r.new_vel_y <= to_io(nv8_r[1]);
      out_data_r.new_vel_z <= to_io(nv8_r[2]);
      out_data_r.new_pos_x <= to_io(add_s(p8_r[0], pd8_r[0]));
      out_data_r.new_pos_y <= to_io(add_s(p8_r[1], pd8_r[1]));
      out_data_r.new_pos_z <= to_io(add_s(p8_r[2], pd8_r[2]));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------- assertions
  `BPP_ASSERT_IMP(a_den_min, clk, rst_n, v3_r, den3_r >= ONE_D)
  `BPP_ASSERT_IMP(a_div_align, clk, rst_n, 1'b1, dv[0] == dv[1] && dv[0] == dv[2])
  `BPP_ASSERT_NXT(a_s1_moves, clk, rst_n, v1_r && en, v2_r)
  `BPP_ASSERT_NXT(a_hold_tail, clk, rst_n, !en, $stable(v8_r) && $stable(nv8_r[0]))

endmodule
